// ===== rtl/hapb_pkg.sv =====
`timescale 1ns / 1ps

package hapb_pkg;

    localparam int MAX_BYTES = 32;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_FILL = 2'd1;

    localparam int MODE_DIGITS = 0;
    localparam int MODE_FORE   = 1;
    localparam int MODE_FILL   = 2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_QMARK  = 8'h3F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       first_char;
        logic       last_char;
        logic [6:0] string_length;
        logic [5:0] buffer_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic [1:0] status;
        logic       conversion_done;
        logic [5:0] result_length;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } nibble_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_FRONT,
        SEQ_DATA,
        SEQ_TAIL,
        SEQ_BACK,
        SEQ_FAIL
    } seq_state_t;

    function automatic seq_state_t next_phase(
        input logic [5:0] front_cnt,
        input logic       data_en,
        input logic       tail_en,
        input logic       back_en,
        input logic [5:0] bytes_done,
        input logic [5:0] saved_len
    );
        seq_state_t nxt;
        if (front_cnt != 6'd0) begin
            nxt = SEQ_FRONT;
        end else if (data_en) begin
            nxt = SEQ_DATA;
        end else if (tail_en) begin
            nxt = SEQ_TAIL;
        end else if (back_en && (bytes_done < saved_len)) begin
            nxt = SEQ_BACK;
        end else begin
            nxt = SEQ_IDLE;
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/hapb_char_decode.sv =====
`timescale 1ns / 1ps

module hapb_char_decode (
    input  logic [7:0]       ascii_char,
    input  logic             digits_only,
    output hapb_pkg::nibble_t dec
);
    import hapb_pkg::*;

    always_comb begin
        dec = '0;
        if (digits_only) begin
            if (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_QMARK) begin
                dec.valid  = 1'b1;
                dec.nibble = ascii_char[3:0];
            end
        end else if ((ascii_char >= CHAR_LOWER_A && ascii_char <= CHAR_LOWER_F) ||
                     (ascii_char >= CHAR_UPPER_A && ascii_char <= CHAR_UPPER_F)) begin
            dec.valid  = 1'b1;
            dec.nibble = ascii_char[3:0] + HEX_LETTER_OFFSET;
        end else if (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_NINE) begin
            dec.valid  = 1'b1;
            dec.nibble = ascii_char[3:0];
        end
    end

endmodule

// ===== rtl/hex_ascii_to_packed_bcd.sv =====
`timescale 1ns / 1ps

// ASCII hex / digit string to packed BCD converter.
// Input channel s_valid/s_ready/s_data carries one character per transaction,
// with first/last markers; string and buffer lengths are sampled on the first.
// Output channel m_valid/m_ready/m_data carries packed bytes, high nibble
// first, plus status, done, result length and a last-of-run marker.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata):
// index 0 is the conversion mode, index 1 the fill digit.
// A small sequencer walks front fill, data byte, trailing nibble and back
// fill, one byte per cycle while the output register is free, through a
// shared emit-count/compare unit. The first result is written into the
// output register from the sequencer's first phase state, not on acceptance.
// s_ready is high only while the sequencer is idle; the next character can be
// taken while the final result still sits in the output register.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset (aresetn low, synchronous) clears configuration, string state and the
// output valid flag; no results are pending afterward.

module hex_ascii_to_packed_bcd (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hapb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hapb_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_wdata
);
    import hapb_pkg::*;

    seq_state_t state_reg, state_next;
    logic [2:0] conversion_mode_reg;
    logic [3:0] fill_digit_reg;
    logic [3:0] held_nibble_reg, held_nibble_next;
    logic       nibble_pending_reg, nibble_pending_next;
    logic [5:0] bytes_emitted_reg, bytes_emitted_next;
    logic [5:0] saved_len_reg, saved_len_next;
    logic       dropping_reg, dropping_next;
    logic [5:0] front_cnt_reg, front_cnt_next;
    logic       data_en_reg, data_en_next;
    logic       tail_en_reg, tail_en_next;
    logic       back_en_reg, back_en_next;
    logic       last_reg, last_next;
    logic [7:0] data_byte_reg, data_byte_next;
    logic [7:0] tail_byte_reg, tail_byte_next;
    logic [1:0] fail_status_reg, fail_status_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    nibble_t    dec;
    logic       accept;
    logic       out_free;
    logic       fore, fill;
    logic [7:0] fill_byte;
    logic [5:0] blen_sat;
    logic [6:0] slen_eff;
    logic [6:0] half_len;
    logic [6:0] front_diff;
    logic       too_small;
    logic       pend_eff;
    logic [3:0] held_eff;
    logic [5:0] bytes_base;
    logic [5:0] saved_base;
    logic [5:0] bytes_after;
    logic [5:0] front_after;
    logic       room;
    seq_state_t nxt;
    logic       fin;

    hapb_char_decode u_decode (
        .ascii_char  (s_data.ascii_char),
        .digits_only (conversion_mode_reg[MODE_DIGITS]),
        .dec         (dec)
    );

    assign s_ready   = (state_reg == SEQ_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign fore      = conversion_mode_reg[MODE_FORE];
    assign fill      = conversion_mode_reg[MODE_FILL];
    assign fill_byte = {fill_digit_reg, fill_digit_reg};

    assign blen_sat   = (s_data.buffer_length > 6'(MAX_BYTES)) ? 6'(MAX_BYTES)
                                                               : s_data.buffer_length;
    assign slen_eff   = (s_data.string_length == 7'd0) ? 7'd1 : s_data.string_length;
    assign half_len   = 7'(({1'b0, slen_eff} + 8'd1) >> 1);
    assign front_diff = {1'b0, blen_sat} - half_len;
    assign too_small  = ({blen_sat, 1'b0} < slen_eff);
    assign bytes_base = s_data.first_char ? 6'd0 : bytes_emitted_reg;
    assign saved_base = s_data.first_char ? blen_sat : saved_len_reg;
    assign pend_eff   = s_data.first_char ? (fore && slen_eff[0]) : nibble_pending_reg;
    assign held_eff   = s_data.first_char ? fill_digit_reg : held_nibble_reg;
    assign room       = bytes_emitted_reg < saved_len_reg;
    assign bytes_after = bytes_emitted_reg + 6'd1;
    assign front_after = (state_reg == SEQ_FRONT) ? front_cnt_reg - 6'd1 : front_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conversion_mode_reg <= '0;
            fill_digit_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE: conversion_mode_reg <= cfg_wdata[2:0];
                CFG_FILL: fill_digit_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= SEQ_IDLE;
            held_nibble_reg    <= '0;
            nibble_pending_reg <= 1'b0;
            bytes_emitted_reg  <= '0;
            saved_len_reg      <= '0;
            dropping_reg       <= 1'b0;
            front_cnt_reg      <= '0;
            data_en_reg        <= 1'b0;
            tail_en_reg        <= 1'b0;
            back_en_reg        <= 1'b0;
            last_reg           <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            held_nibble_reg    <= held_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
            bytes_emitted_reg  <= bytes_emitted_next;
            saved_len_reg      <= saved_len_next;
            dropping_reg       <= dropping_next;
            front_cnt_reg      <= front_cnt_next;
            data_en_reg        <= data_en_next;
            tail_en_reg        <= tail_en_next;
            back_en_reg        <= back_en_next;
            last_reg           <= last_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_byte_reg   <= data_byte_next;
        tail_byte_reg   <= tail_byte_next;
        fail_status_reg <= fail_status_next;
        m_data_reg      <= m_data_next;
    end

    always_comb begin
        state_next          = state_reg;
        held_nibble_next    = held_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        bytes_emitted_next  = bytes_emitted_reg;
        saved_len_next      = saved_len_reg;
        dropping_next       = dropping_reg;
        front_cnt_next      = front_cnt_reg;
        data_en_next        = data_en_reg;
        tail_en_next        = tail_en_reg;
        back_en_next        = back_en_reg;
        last_next           = last_reg;
        data_byte_next      = data_byte_reg;
        tail_byte_next      = tail_byte_reg;
        fail_status_next    = fail_status_reg;
        m_data_next         = m_data_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        nxt                 = SEQ_IDLE;
        fin                 = 1'b0;

        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    if (s_data.first_char) begin
                        saved_len_next      = blen_sat;
                        bytes_emitted_next  = '0;
                        nibble_pending_next = 1'b0;
                        held_nibble_next    = '0;
                        dropping_next       = 1'b0;
                    end
                    if (!s_data.first_char && dropping_reg) begin
                        // ignored until the next first character
                    end else if (s_data.first_char && too_small) begin
                        fail_status_next    = STATUS_NO_ROOM;
                        state_next          = SEQ_FAIL;
                        dropping_next       = 1'b1;
                        nibble_pending_next = 1'b0;
                    end else if (!dec.valid) begin
                        fail_status_next    = STATUS_BAD_CHAR;
                        state_next          = SEQ_FAIL;
                        dropping_next       = 1'b1;
                        nibble_pending_next = 1'b0;
                    end else begin
                        front_cnt_next = (s_data.first_char && fill && fore) ? front_diff[5:0]
                                                                             : 6'd0;
                        data_en_next   = pend_eff;
                        tail_en_next   = s_data.last_char && !pend_eff;
                        back_en_next   = s_data.last_char && fill && !fore;
                        last_next      = s_data.last_char;
                        data_byte_next = {held_eff, dec.nibble};
                        tail_byte_next = {dec.nibble, fill_digit_reg};
                        if (!pend_eff) begin
                            held_nibble_next = dec.nibble;
                        end
                        nibble_pending_next = !pend_eff && !s_data.last_char;
                        dropping_next       = s_data.last_char;
                        state_next = next_phase(front_cnt_next, data_en_next, tail_en_next,
                                                back_en_next, bytes_base, saved_base);
                    end
                end
            end
            SEQ_FAIL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{packed_byte: 8'd0, status: fail_status_reg,
                                     conversion_done: 1'b1, result_length: 6'd0,
                                     last_of_run: 1'b1};
                    state_next   = SEQ_IDLE;
                end
            end
            SEQ_FRONT, SEQ_DATA, SEQ_TAIL, SEQ_BACK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (!room) begin
                        m_data_next = '{packed_byte: 8'd0, status: STATUS_NO_ROOM,
                                        conversion_done: 1'b1, result_length: 6'd0,
                                        last_of_run: 1'b1};
                        dropping_next       = 1'b1;
                        nibble_pending_next = 1'b0;
                        state_next          = SEQ_IDLE;
                    end else begin
                        front_cnt_next     = front_after;
                        if (state_reg == SEQ_DATA) begin
                            data_en_next = 1'b0;
                        end
                        if (state_reg == SEQ_TAIL) begin
                            tail_en_next = 1'b0;
                        end
                        bytes_emitted_next = bytes_after;
                        nxt = next_phase(front_after, data_en_next, tail_en_next,
                                         back_en_reg, bytes_after, saved_len_reg);
                        fin = (nxt == SEQ_IDLE);
                        m_data_next.status          = STATUS_OK;
                        m_data_next.last_of_run     = fin;
                        m_data_next.conversion_done = last_reg && fin;
                        m_data_next.result_length   = (last_reg && fin)
                                                      ? (fill ? saved_len_reg : bytes_after)
                                                      : 6'd0;
                        case (state_reg)
                            SEQ_DATA: m_data_next.packed_byte = data_byte_reg;
                            SEQ_TAIL: m_data_next.packed_byte = tail_byte_reg;
                            default:  m_data_next.packed_byte = fill_byte;
                        endcase
                        state_next = nxt;
                    end
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

endmodule

// ===== bench/tb_hex_ascii_to_packed_bcd.sv =====
`timescale 1ns / 1ps

module tb_hex_ascii_to_packed_bcd;
    import hapb_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 40;
    localparam int LONG_HOLD = 150;
    localparam int PHASE_CHARS = 4;

    typedef struct {
        bit         is_cfg;
        logic [1:0] reg_idx;
        logic [3:0] reg_val;
        in_item_t   chr;
        bit         typed;
        out_item_t  want;
    } table_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_MODE;
    logic [3:0] cfg_wdata = 4'd0;

    // packing predictor state
    logic [2:0] conv_mode;
    logic [3:0] pad_nibble;
    logic [3:0] held_nib;
    bit         nib_held;
    int         bytes_out;
    int         buf_bytes;
    bit         skip_rest;

    out_item_t  run_bytes[$];
    out_item_t  pending_bytes[$];
    table_row_t stim_table[$];

    int       failures = 0;
    int       chars_sent = 0;
    int       rand_chars = 0;
    int       strings_sent = 0;
    int       bytes_checked = 0;
    bit [7:0] modes_seen = '0;
    bit       hold_req = 1'b0;
    bit       tx_steady = 1'b0;

    hex_ascii_to_packed_bcd dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("hex_ascii_to_packed_bcd regression: fail");
        $finish;
    end

    function automatic int nibble_of(logic [7:0] c, bit digits);
        if (digits) begin
            if (c >= CHAR_ZERO && c <= CHAR_QMARK) return int'(c - CHAR_ZERO);
            return -1;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return int'(c - CHAR_LOWER_A) + 10;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
        return -1;
    endfunction

    function automatic bit emit_byte(logic [7:0] b);
        if (bytes_out >= buf_bytes) return 1'b0;
        run_bytes.push_back('{packed_byte: b, status: STATUS_OK, conversion_done: 1'b0,
                              result_length: 6'd0, last_of_run: 1'b0});
        bytes_out++;
        return 1'b1;
    endfunction

    function automatic void abort_string(logic [1:0] st);
        run_bytes.push_back('{packed_byte: 8'h00, status: st, conversion_done: 1'b1,
                              result_length: 6'd0, last_of_run: 1'b1});
        skip_rest = 1'b1;
        nib_held = 1'b0;
    endfunction

    function automatic void predict_packing(in_item_t it);
        bit         digits;
        bit         fore;
        bit         fill_all;
        logic [7:0] fill_byte;
        int         slen;
        int         blen;
        int         nib;
        int         gap;
        int         i;
        int         n;
        run_bytes.delete();
        digits = conv_mode[MODE_DIGITS];
        fore = conv_mode[MODE_FORE];
        fill_all = conv_mode[MODE_FILL];
        fill_byte = {pad_nibble, pad_nibble};
        slen = 1;
        if (it.first_char) begin
            slen = int'(it.string_length);
            if (slen == 0) slen = 1;
            blen = int'(it.buffer_length);
            if (blen > MAX_BYTES) blen = MAX_BYTES;
            buf_bytes = blen;
            bytes_out = 0;
            nib_held = 1'b0;
            held_nib = 4'd0;
            skip_rest = 1'b0;
            if (2 * blen < slen) begin
                abort_string(STATUS_NO_ROOM);
                return;
            end
        end else if (skip_rest) begin
            return;
        end
        nib = nibble_of(it.ascii_char, digits);
        if (nib < 0) begin
            abort_string(STATUS_BAD_CHAR);
            return;
        end
        if (it.first_char) begin
            if (fill_all && fore) begin
                gap = buf_bytes - (slen + 1) / 2;
                for (i = 0; i < gap; i++) begin
                    if (!emit_byte(fill_byte)) begin
                        abort_string(STATUS_NO_ROOM);
                        return;
                    end
                end
            end
            if (fore && (slen % 2 == 1)) begin
                held_nib = pad_nibble;
                nib_held = 1'b1;
            end
        end
        if (nib_held) begin
            if (!emit_byte({held_nib, 4'(nib)})) begin
                abort_string(STATUS_NO_ROOM);
                return;
            end
            nib_held = 1'b0;
        end else begin
            held_nib = 4'(nib);
            nib_held = 1'b1;
        end
        if (it.last_char) begin
            if (nib_held) begin
                if (!emit_byte({held_nib, pad_nibble})) begin
                    abort_string(STATUS_NO_ROOM);
                    return;
                end
                nib_held = 1'b0;
            end
            if (fill_all && !fore) begin
                while (bytes_out < buf_bytes) void'(emit_byte(fill_byte));
            end
            n = run_bytes.size();
            if (n > 0) begin
                run_bytes[n-1].conversion_done = 1'b1;
                run_bytes[n-1].result_length = fill_all ? 6'(buf_bytes) : 6'(bytes_out);
            end
            skip_rest = 1'b1;
        end
        n = run_bytes.size();
        if (n > 0) run_bytes[n-1].last_of_run = 1'b1;
    endfunction

    function automatic void add_row(logic [7:0] c, bit f, bit l, int sl, int bl,
                                    bit typed, logic [1:0] st);
        table_row_t row;
        row.is_cfg = 1'b0;
        row.reg_idx = CFG_MODE;
        row.reg_val = 4'd0;
        row.chr = '{ascii_char: c, first_char: f, last_char: l,
                    string_length: 7'(sl), buffer_length: 6'(bl)};
        row.typed = typed;
        row.want = '{packed_byte: 8'h00, status: st, conversion_done: 1'b1,
                     result_length: 6'd0, last_of_run: 1'b1};
        stim_table.push_back(row);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [3:0] val);
        table_row_t row;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.chr = '0;
        row.typed = 1'b0;
        row.want = '0;
        stim_table.push_back(row);
    endfunction

    function automatic logic [7:0] legal_char();
        int r;
        if (conv_mode[MODE_DIGITS]) return CHAR_ZERO + 8'($urandom_range(0, 15));
        r = $urandom_range(0, 2);
        if (r == 0) return CHAR_ZERO + 8'($urandom_range(0, 9));
        if (r == 1) return CHAR_UPPER_A + 8'($urandom_range(0, 5));
        return CHAR_LOWER_A + 8'($urandom_range(0, 5));
    endfunction

    task automatic check_byte(out_item_t got);
        out_item_t want;
        if (pending_bytes.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected byte %h status %0d done %0d len %0d last %0d",
                         got.packed_byte, got.status, got.conversion_done,
                         got.result_length, got.last_of_run);
            return;
        end
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (got.packed_byte !== want.packed_byte || got.status !== want.status ||
            got.conversion_done !== want.conversion_done ||
            got.result_length !== want.result_length ||
            got.last_of_run !== want.last_of_run) begin
            failures++;
            if (failures <= 10)
                $display("mismatch at byte %0d: want %h/%0d/%0d/%0d/%0d got %h/%0d/%0d/%0d/%0d",
                         bytes_checked, want.packed_byte, want.status,
                         want.conversion_done, want.result_length, want.last_of_run,
                         got.packed_byte, got.status, got.conversion_done,
                         got.result_length, got.last_of_run);
        end
    endtask

    task automatic send_char(in_item_t it, bit typed, out_item_t want, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_packing(it);
        if (typed) pending_bytes.push_back(want);
        else foreach (run_bytes[k]) pending_bytes.push_back(run_bytes[k]);
        chars_sent++;
        if (it.first_char) strings_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MODE) begin
            conv_mode = val[2:0];
            modes_seen[val[2:0]] = 1'b1;
        end else begin
            pad_nibble = val;
        end
        @(posedge aclk);
    endtask

    task automatic send_string(int sl, int bl, int count);
        in_item_t it;
        int       i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 32) == 0) it.ascii_char = 8'($urandom_range(0, 255));
            else it.ascii_char = legal_char();
            it.first_char = (i == 0);
            it.last_char = (i == count - 1);
            it.string_length = (i == 0) ? 7'(sl) : 7'($urandom_range(0, 127));
            it.buffer_length = (i == 0) ? 6'(bl) : 6'($urandom_range(0, 63));
            send_char(it, 1'b0, '0, tx_steady);
            rand_chars++;
        end
    endtask

    task automatic random_string();
        in_item_t stray;
        int       sl;
        int       bl;
        int       cnt;
        int       r;
        sl = ($urandom_range(0, 23) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
        bl = (sl + 1) / 2 + $urandom_range(0, 3);
        r = $urandom_range(0, 19);
        if (r == 0) bl = $urandom_range(0, (sl - 1) / 2);
        else if (r == 1) bl = $urandom_range(33, 63);
        cnt = sl;
        r = $urandom_range(0, 15);
        if (r == 0) cnt = sl + $urandom_range(1, 4);
        else if (r == 1 && sl > 1) cnt = $urandom_range(1, sl - 1);
        if ($urandom_range(0, 24) == 0) begin
            sl = 0;
            cnt = 1;
            bl = $urandom_range(1, 4);
        end
        if ($urandom_range(0, 11) == 0) begin
            stray = '{ascii_char: legal_char(), first_char: 1'b0,
                      last_char: 1'($urandom_range(0, 1)),
                      string_length: 7'($urandom_range(0, 127)),
                      buffer_length: 6'($urandom_range(0, 63))};
            send_char(stray, 1'b0, '0, tx_steady);
        end
        send_string(sl, bl, cnt);
    endtask

    initial begin : receiver
        int rx_wait;
        bit rx_steady;
        rx_wait = 0;
        rx_steady = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                check_byte(m_data);
                if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
            end
            if (hold_req) begin
                rx_wait = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int p;
        int phase_start;
        conv_mode = 3'd0;
        pad_nibble = 4'd0;
        held_nib = 4'd0;
        nib_held = 1'b0;
        bytes_out = 0;
        buf_bytes = 0;
        skip_rest = 1'b0;

        // continuation right after reset overflows a zero-size buffer
        add_row("7", 1'b0, 1'b1, 0, 0, 1'b1, STATUS_NO_ROOM);
        add_row("3", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("1", 1'b1, 1'b1, 127, 63, 1'b1, STATUS_NO_ROOM);
        add_row("0", 1'b1, 1'b0, 2, 1, 1'b0, STATUS_OK);
        add_row("F", 1'b0, 1'b1, 2, 1, 1'b0, STATUS_OK);
        add_row("g", 1'b1, 1'b1, 1, 4, 1'b1, STATUS_BAD_CHAR);
        add_row(8'h00, 1'b1, 1'b1, 1, 1, 1'b1, STATUS_BAD_CHAR);
        add_row(8'hFF, 1'b1, 1'b1, 1, 1, 1'b1, STATUS_BAD_CHAR);
        add_row("a", 1'b1, 1'b0, 5, 3, 1'b0, STATUS_OK);
        add_row("f", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("A", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("F", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("9", 1'b0, 1'b1, 0, 0, 1'b0, STATUS_OK);
        // open string abandoned by a new first character
        add_row("1", 1'b1, 1'b0, 4, 2, 1'b0, STATUS_OK);
        add_row("2", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("3", 1'b1, 1'b1, 1, 40, 1'b0, STATUS_OK);
        // more characters than announced
        add_row("b", 1'b1, 1'b0, 2, 1, 1'b0, STATUS_OK);
        add_row("c", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("d", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("e", 1'b0, 1'b1, 0, 0, 1'b0, STATUS_OK);
        add_reg(CFG_MODE, 4'd7);
        add_reg(CFG_FILL, 4'd15);
        add_row("?", 1'b1, 1'b0, 3, 4, 1'b0, STATUS_OK);
        add_row(":", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("5", 1'b0, 1'b1, 0, 0, 1'b0, STATUS_OK);
        add_row("0", 1'b1, 1'b1, 0, 2, 1'b0, STATUS_OK);
        add_row("a", 1'b1, 1'b1, 1, 1, 1'b1, STATUS_BAD_CHAR);
        add_reg(CFG_MODE, 4'd4);
        add_reg(CFG_FILL, 4'd10);
        add_row("1", 1'b1, 1'b0, 3, 5, 1'b0, STATUS_OK);
        add_row("2", 1'b0, 1'b0, 0, 0, 1'b0, STATUS_OK);
        add_row("3", 1'b0, 1'b1, 0, 0, 1'b0, STATUS_OK);
        add_row("4", 1'b1, 1'b0, 2, 2, 1'b0, STATUS_OK);
        add_row("x", 1'b0, 1'b1, 0, 0, 1'b1, STATUS_BAD_CHAR);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[r]) begin
            if (stim_table[r].is_cfg) begin
                wait_drained();
                write_reg(stim_table[r].reg_idx, stim_table[r].reg_val);
            end else begin
                send_char(stim_table[r].chr, stim_table[r].typed, stim_table[r].want, 1'b0);
            end
        end

        for (p = 0; p < 8; p++) begin
            wait_drained();
            write_reg(CFG_MODE, 4'((p * 5) % 8));
            write_reg(CFG_FILL, (p == 0) ? 4'd0 : (p == 7) ? 4'd15 : 4'($urandom_range(0, 15)));
            tx_steady = (p % 3 == 2);
            phase_start = rand_chars;
            if (p == 1) begin
                // output held off while a long string keeps coming
                hold_req = 1'b1;
                tx_steady = 1'b1;
                send_string(20, 10, 20);
                tx_steady = 1'b0;
            end
            while (rand_chars - phase_start < PHASE_CHARS) begin
                random_string();
                if (p == 4 && rand_chars - phase_start < 8) wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        failures += pending_bytes.size();
        $display("%0d characters in %0d strings, %0d packed bytes checked", chars_sent,
                 strings_sent, bytes_checked);
        $display("%0d of 8 conversion modes run, directed edge rows plus random strings",
                 $countones(modes_seen));
        if (failures == 0) begin
            $display("hex_ascii_to_packed_bcd regression: pass");
        end else begin
            $display("hex_ascii_to_packed_bcd regression: fail");
        end
        $finish;
    end

endmodule
